// ===== src/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types, constants and helpers for the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  // Ring depth and derived widths
  localparam int MAX_DEPTH  = 256;
  localparam int PTR_W      = $clog2(MAX_DEPTH);
  localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
  localparam int SAMPLE_W   = 32;
  localparam int WLEN_W     = 9;
  localparam int IDX_W      = 8;
  localparam int WLEN_RESET = 100;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_TEST,
    ST_EV_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_READ_WAIT,
    ST_RESULT
  } swmm_state_t;

  typedef struct packed {
    op_t                operation;
    sample_t            sample_value;
    logic [IDX_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    sample_t            read_value;
    sample_t            min_value;
    sample_t            max_value;
    logic [WLEN_W-1:0]  sample_count;
  } out_item_t;

  // Ring pointer plus offset, wrapped at the ring depth
  function automatic ptr_t wrap_add(ptr_t base, ptr_t ofs);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (PTR_W+1)'(MAX_DEPTH)) begin
      sum = sum - (PTR_W+1)'(MAX_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Clamp the programmed window length into 1..MAX_DEPTH
  function automatic cnt_t eff_len(logic [WLEN_W-1:0] wl);
    cnt_t r;
    if (wl == '0) begin
      r = cnt_t'(1);
    end else if (32'(wl) > MAX_DEPTH) begin
      r = cnt_t'(MAX_DEPTH);
    end else begin
      r = cnt_t'(wl);
    end
    return r;
  endfunction

endpackage

// ===== src/swmm_ram.sv =====
// ----------------------------------------------------------------------------
// swmm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/swmm_core.sv =====
// ----------------------------------------------------------------------------
// swmm_core
// Sequencer around the sample ring: push with eviction and rescan, and reads.
// ----------------------------------------------------------------------------
module swmm_core
  import swmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  input  logic [WLEN_W-1:0] wlen,
  output logic              res_valid,
  input  logic              res_ready,
  output out_item_t         res_data
);

  swmm_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;
  sample_t     v_r, v_nxt;
  cnt_t        len_r, len_nxt;
  ptr_t        oldest_r, oldest_nxt;
  cnt_t        held_r, held_nxt;
  sample_t     min_r, min_nxt;
  sample_t     max_r, max_nxt;
  sample_t     best_r, best_nxt;
  logic        want_max_r, want_max_nxt;
  cnt_t        scan_i_r, scan_i_nxt;
  logic        pend_r, pend_nxt;
  sample_t     rd_val_r, rd_val_nxt;

  logic        ram_we;
  ptr_t        ram_waddr;
  logic        ram_re;
  ptr_t        ram_raddr;
  sample_t     ram_q;
  logic [SAMPLE_W-1:0] ram_q_raw;
  sample_t     best_upd;

  assign ram_q = sample_t'(ram_q_raw);

  swmm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (v_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q_raw)
  );

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oldest_r <= '0;
      held_r   <= '0;
      min_r    <= '0;
      max_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      held_r   <= held_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Hold item and scan payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    v_r        <= v_nxt;
    len_r      <= len_nxt;
    best_r     <= best_nxt;
    want_max_r <= want_max_nxt;
    scan_i_r   <= scan_i_nxt;
    rd_val_r   <= rd_val_nxt;
  end

  // Candidate best value from the sample that returns this cycle
  always_comb begin
    best_upd = best_r;
    if (pend_r) begin
      if (want_max_r ? (ram_q > best_r) : (ram_q < best_r)) begin
        best_upd = ram_q;
      end
    end
  end

  // Sequence one item through the ring
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    v_nxt        = v_r;
    len_nxt      = len_r;
    oldest_nxt   = oldest_r;
    held_nxt     = held_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    best_nxt     = best_r;
    want_max_nxt = want_max_r;
    scan_i_nxt   = scan_i_r;
    pend_nxt     = 1'b0;
    rd_val_nxt   = rd_val_r;
    ram_we       = 1'b0;
    ram_waddr    = wrap_add(oldest_r, held_r[PTR_W-1:0]);
    ram_re       = 1'b0;
    ram_raddr    = oldest_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_data.operation;
          v_nxt   = in_data.sample_value;
          len_nxt = eff_len(wlen);
          if (in_data.operation == OP_PUSH) begin
            // First sample sets both extremes, later ones widen them
            if (held_r == '0) begin
              min_nxt = in_data.sample_value;
              max_nxt = in_data.sample_value;
            end else begin
              if (in_data.sample_value > max_r) max_nxt = in_data.sample_value;
              if (in_data.sample_value < min_r) min_nxt = in_data.sample_value;
            end
            state_nxt = ST_EV_TEST;
          end else if (cnt_t'(in_data.read_index) < held_r) begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(oldest_r, ptr_t'(in_data.read_index));
            state_nxt = ST_READ_WAIT;
          end else begin
            rd_val_nxt = '0;
            state_nxt  = ST_RESULT;
          end
        end
      end

      ST_EV_TEST: begin
        // Evict while the window would overflow with the new sample
        if ((held_r >= len_r) && (held_r != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = oldest_r;
          state_nxt = ST_EV_CHECK;
        end else begin
          state_nxt = ST_WRITE;
        end
      end

      ST_EV_CHECK: begin
        oldest_nxt   = wrap_add(oldest_r, ptr_t'(1));
        held_nxt     = held_r - cnt_t'(1);
        best_nxt     = v_r;
        scan_i_nxt   = '0;
        if (ram_q >= max_r) begin
          want_max_nxt = 1'b1;
          state_nxt    = ST_SCAN;
        end else if (ram_q <= min_r) begin
          want_max_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end else begin
          state_nxt    = ST_EV_TEST;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle, fold the returning sample
        best_nxt = best_upd;
        if (scan_i_r < held_r) begin
          ram_re     = 1'b1;
          ram_raddr  = wrap_add(oldest_r, scan_i_r[PTR_W-1:0]);
          scan_i_nxt = scan_i_r + cnt_t'(1);
          pend_nxt   = 1'b1;
        end else if (!pend_r) begin
          if (want_max_r) begin
            max_nxt = best_upd;
          end else begin
            min_nxt = best_upd;
          end
          state_nxt = ST_EV_TEST;
        end
      end

      ST_WRITE: begin
        ram_we     = 1'b1;
        held_nxt   = held_r + cnt_t'(1);
        rd_val_nxt = '0;
        state_nxt  = ST_RESULT;
      end

      ST_READ_WAIT: begin
        rd_val_nxt = ram_q;
        state_nxt  = ST_RESULT;
      end

      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_data.read_value   = rd_val_r;
  assign res_data.min_value    = min_r;
  assign res_data.max_value    = max_r;
  assign res_data.sample_count = WLEN_W'(held_r);

  // Checks
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cnt_t'(MAX_DEPTH))
    else $error("held count beyond ring depth");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && op_r == OP_PUSH) |-> (held_r <= len_r && held_r != '0))
    else $error("push left window over length or empty");

  a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> (min_r <= max_r))
    else $error("window minimum above maximum");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> (held_r == $past(held_r) + cnt_t'(1)))
    else $error("ring write did not advance the count");

endmodule

// ===== src/sliding_window_min_max.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Window of recent Q16.16 samples with running minimum and maximum.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_item_t (operation, sample, index)
//  out_     output     out_valid/out_ready  out_item_t (read, min, max, count)
//  cfg_     input      cfg_wr_en            cfg_wr_data (window length)
//
//  Read: an in-range index passes READ_WAIT, an out-of-range one goes straight
//  to RESULT. Push: each eviction passes EV_TEST and EV_CHECK, then SCAN of the
//  held samples if it took an extreme (a shrunk window repeats this); WRITE and
//  RESULT end the push. SCAN is paced by the one ring read port, one sample a cycle.
//  Synchronous active-low reset; the ring needs no clearing pass.
//  One result register decouples the sides: the next item is taken while
//  a result waits; a result waiting at the end of an item stalls the core.
// ----------------------------------------------------------------------------
module sliding_window_min_max
  import swmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [WLEN_W-1:0] cfg_wr_data
);

  logic [WLEN_W-1:0] wlen_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_data;
  logic              res_xfer;

  swmm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .wlen      (wlen_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_W'(WLEN_RESET);
    end else if (cfg_wr_en) begin
      wlen_r <= cfg_wr_data;
    end
  end

  // Result register: load on transfer from the core, drop on output transfer
  assign res_ready     = !out_valid_r || out_ready;
  assign res_xfer      = res_valid && res_ready;
  assign out_valid_nxt = res_xfer || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_xfer) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/tb_sliding_window_min_max.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max
// Self-checking bench for the sliding window min/max block. A short scripted
// run after reset covers the rails, empty-window reads, out-of-range reads and
// window length clamping and shrinking. Random phases at several window
// lengths follow: ramps, ties, rails and noise. Every result is compared
// field by field with a typed value or the in-bench window model; both sides of
// the block are throttled and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max
  import swmm_pkg::*;
();

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int LONG_HOLD_AFTER  = 700;
  localparam int DRAIN_CYCLES     = MAX_DEPTH + 16;
  // Worst quiet stretch: a shrink to one slot rescanning on every eviction
  localparam int WATCHDOG_LIMIT   = 4 * MAX_DEPTH * (MAX_DEPTH + 4);
  localparam int RANDOM_LEN       = -1;
  localparam int PHASES           = 12;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef enum int {
    SHAPE_RISE,
    SHAPE_FALL,
    SHAPE_LEVELS,
    SHAPE_NOISE,
    SHAPE_RAILS
  } shape_t;

  typedef struct packed {
    row_kind_t         kind;
    in_item_t          item;
    logic [WLEN_W-1:0] cfg_value;
    logic              typed;
    out_item_t         result;
  } script_row_t;

  // Scripted opening: typed results where they are obvious, model elsewhere
  localparam int SCRIPT_ROWS = 22;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd0}, 9'd0, 1'b1,
      '{32'sh0, 32'sh0, 32'sh0, 9'd0}},
    '{ROW_ITEM, '{OP_PUSH, 32'sh7FFF_FFFF, 8'd0}, 9'd0, 1'b1,
      '{32'sh0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 9'd1}},
    '{ROW_ITEM, '{OP_PUSH, 32'sh8000_0000, 8'd0}, 9'd0, 1'b1,
      '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 9'd2}},
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd0}, 9'd0, 1'b1,
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 9'd2}},
    '{ROW_ITEM, '{OP_READ, 32'shFFFF_FFFF, 8'd1}, 9'd0, 1'b1,
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 9'd2}},
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd2}, 9'd0, 1'b1,
      '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 9'd2}},
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd255}, 9'd0, 1'b1,
      '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 9'd2}},
    '{ROW_CFG, '{OP_PUSH, 32'sh0, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'sh0000_0005, 8'd0}, 9'd0, 1'b1,
      '{32'sh0, 32'sh0000_0005, 32'sh0000_0005, 9'd1}},
    '{ROW_ITEM, '{OP_PUSH, 32'shFFFF_FFFD, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_CFG, '{OP_PUSH, 32'sh0, 8'd0}, 9'd511, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'sh0001_0000, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'shFFFF_0000, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'shFFFF_FFFD, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_CFG, '{OP_PUSH, 32'sh0, 8'd0}, 9'd2, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'sh0000_8000, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'shFFFF_FFFD, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd1}, 9'd0, 1'b0, '0},
    '{ROW_CFG, '{OP_PUSH, 32'sh0, 8'd0}, 9'd256, 1'b0, '0},
    '{ROW_ITEM, '{OP_PUSH, 32'sh7FFF_FFFF, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{OP_READ, 32'sh0, 8'd200}, 9'd0, 1'b0, '0}
  };

  // Random phases: window length and item count; small windows dominate
  localparam int PLAN_LEN [PHASES] =
    '{2, 1, 256, 3, 0, 511, 17, 300, 8, RANDOM_LEN, 256, 5};
  localparam int PLAN_ITEMS [PHASES] =
    '{160, 80, 320, 130, 100, 200, 150, 100, 200, 150, 80, 80};

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en   = 1'b0;
  logic [WLEN_W-1:0] cfg_wr_data = '0;

  // Window model
  sample_t           ring_model [MAX_DEPTH];
  int                oldest_model;
  int                held_model;
  sample_t           win_min;
  sample_t           win_max;
  logic [WLEN_W-1:0] win_len_reg;

  out_item_t stats_due [$];
  int        mismatches  = 0;
  int        items_taken = 0;
  int        burst_left  = 0;
  int        stall_cycles = 0;
  shape_t    shape;
  sample_t   ramp_level;

  sliding_window_min_max DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Best of the held samples and the incoming one
  function automatic sample_t rescan_extreme(logic want_max, sample_t pending);
    sample_t best;
    sample_t s;
    int      i;
    best = pending;
    for (i = 0; i < held_model; i++) begin
      s = ring_model[(oldest_model + i) % MAX_DEPTH];
      if (want_max ? (s > best) : (s < best)) begin
        best = s;
      end
    end
    return best;
  endfunction

  // Advance the window by one item and return the statistics it reports
  function automatic out_item_t window_step(in_item_t it);
    out_item_t r;
    sample_t   v;
    sample_t   gone;
    int        len;
    r = '0;
    v = it.sample_value;
    if (win_len_reg == '0) begin
      len = 1;
    end else if (int'(win_len_reg) > MAX_DEPTH) begin
      len = MAX_DEPTH;
    end else begin
      len = int'(win_len_reg);
    end
    if (it.operation == OP_PUSH) begin
      if (held_model == 0) begin
        win_min = v;
        win_max = v;
      end else begin
        if (v > win_max) win_max = v;
        if (v < win_min) win_min = v;
      end
      // Drop oldest samples until the new one fits
      while (held_model + 1 > len && held_model > 0) begin
        gone = ring_model[oldest_model];
        oldest_model = (oldest_model + 1) % MAX_DEPTH;
        held_model--;
        if (gone >= win_max) begin
          win_max = rescan_extreme(1'b1, v);
        end else if (gone <= win_min) begin
          win_min = rescan_extreme(1'b0, v);
        end
      end
      ring_model[(oldest_model + held_model) % MAX_DEPTH] = v;
      held_model++;
    end else if (int'(it.read_index) < held_model) begin
      r.read_value = ring_model[(oldest_model + int'(it.read_index)) % MAX_DEPTH];
    end
    r.min_value    = win_min;
    r.max_value    = win_max;
    r.sample_count = WLEN_W'(held_model);
    return r;
  endfunction

  // Next sample of the current sequence shape
  function automatic sample_t next_sample();
    sample_t s;
    case (shape)
      SHAPE_RISE: begin
        ramp_level = ramp_level + sample_t'($urandom_range(0, 4) << $urandom_range(0, 16));
        s = ramp_level;
      end
      SHAPE_FALL: begin
        ramp_level = ramp_level - sample_t'($urandom_range(0, 4) << $urandom_range(0, 16));
        s = ramp_level;
      end
      SHAPE_LEVELS: s = sample_t'((int'($urandom_range(0, 4)) - 2) <<< 16);
      SHAPE_RAILS: begin
        case ($urandom_range(0, 4))
          0: s = 32'sh7FFF_FFFF;
          1: s = 32'sh8000_0000;
          2: s = 32'sh0;
          3: s = 32'shFFFF_FFFF;
          default: s = 32'sh1;
        endcase
      end
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation  = ($urandom_range(0, 3) == 0) ? OP_READ : OP_PUSH;
    it.read_index = IDX_W'($urandom_range(0, 255));
    if (it.operation == OP_PUSH) begin
      it.sample_value = next_sample();
    end else begin
      it.sample_value = sample_t'($urandom);
      // Mostly aim inside the held samples
      if (held_model > 0 && $urandom_range(0, 9) < 7) begin
        it.read_index = IDX_W'($urandom_range(0, held_model - 1));
      end
    end
    return it;
  endfunction

  // Offer one item in bursts with gaps; predict on transfer
  task automatic send_item(in_item_t it, logic typed, out_item_t typed_result);
    out_item_t predicted;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_taken++;
    predicted = window_step(it);
    stats_due = {stats_due, (typed ? typed_result : predicted)};
  endtask

  // Write the window length once every outstanding result is back
  task automatic set_window(logic [WLEN_W-1:0] value);
    in_valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    win_len_reg = value;
    burst_left  = 0;
  endtask

  // Stimulus
  initial begin
    int        r;
    int        p;
    int        n;
    int        len;
    int        chunk_left;
    ring_model   = '{default: '0};
    oldest_model = 0;
    held_model   = 0;
    win_min      = '0;
    win_max      = '0;
    win_len_reg  = WLEN_W'(WLEN_RESET);
    shape        = SHAPE_NOISE;
    ramp_level   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the scripted rows
    for (r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        set_window(SCRIPT[r].cfg_value);
      end else begin
        send_item(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].result);
      end
    end

    // Random phases, each a run of shaped sequences
    for (p = 0; p < PHASES; p++) begin
      len = (PLAN_LEN[p] == RANDOM_LEN) ? $urandom_range(1, 511) : PLAN_LEN[p];
      set_window(WLEN_W'(len));
      chunk_left = 0;
      for (n = 0; n < PLAN_ITEMS[p]; n++) begin
        if (chunk_left == 0) begin
          chunk_left = $urandom_range(5, 60);
          shape      = shape_t'($urandom_range(0, 4));
          ramp_level = sample_t'($urandom);
        end
        chunk_left--;
        send_item(random_item(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain and report
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_min_max: match");
    end else begin
      $display("sliding_window_min_max: mismatch");
    end
    $finish;
  end

  // Receiver: stretches of its own stall patterns plus one long hold-off
  initial begin
    int mode;
    int span;
    int tick;
    logic hold_done;
    hold_done = 1'b0;
    tick      = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        if (!hold_done && items_taken >= LONG_HOLD_AFTER) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        tick++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= (tick % 4 != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (stats_due.size() == 0) begin
        $error("result with no expectation waiting");
        mismatches++;
      end else begin
        want = stats_due.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
          mismatches++;
        end
        if (out_data.min_value !== want.min_value) begin
          $error("min_value: expected %0d, got %0d", want.min_value, out_data.min_value);
          mismatches++;
        end
        if (out_data.max_value !== want.max_value) begin
          $error("max_value: expected %0d, got %0d", want.max_value, out_data.max_value);
          mismatches++;
        end
        if (out_data.sample_count !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d",
                 want.sample_count, out_data.sample_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("sliding_window_min_max: mismatch");
      $finish;
    end
  end

endmodule
